/* hdl/dnsqx_pkg.sv */
// Shared constants and types for the DNS query-name extractor.
`timescale 1ns / 1ps

package dnsqx_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam logic [7:0]  POINTER_MASK = 8'hC0;
  localparam logic [7:0]  DOT_CHAR     = 8'h2E;
  localparam logic [7:0]  LIMIT_RESET  = 8'd255;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_LABEL  = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

endpackage

/* hdl/dns_query_name_extractor_top.sv */
// DNS query-name extractor: top level, parse state and result register.
// Takes one message byte per item and returns one result per item. An item
// can be accepted every cycle; its result appears in the output register in the
// cycle after acceptance. The only thing that holds off input is a full output
// register whose result is stalled, so while the output is not stalled the
// sustained rate is one item per clock. The first 12 bytes are skipped, then
// labels are emitted as dotted text, one character per result; the name ends
// on a zero length byte, a compression pointer, the name_limit count or the
// last byte. A message shorter than 13 bytes finishes with parse_status set.
`timescale 1ns / 1ps

module dns_query_name_extractor_top
  import dnsqx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] name_char,
  output logic [7:0] name_length,
  output logic       parse_status
);

  logic [7:0] name_limit;
  phase_t     parse_phase, parse_phase_next;
  logic [3:0] header_count, header_count_next, header_inc;
  logic [7:0] label_remaining, label_remaining_next;
  logic [7:0] emitted_count, emitted_count_next;
  logic [7:0] emitted_inc, emitted_dot;
  kind_t      kind;
  logic [7:0] ch;
  logic       status;
  logic       accept;
  logic       stop_byte;

  assign in_stall    = out_valid && out_stall;
  assign accept      = in_valid && !in_stall;
  assign header_inc  = header_count + 4'd1;
  assign emitted_inc = emitted_count + 8'd1;
  // a dot precedes every label but the first
  assign emitted_dot = (emitted_count != 8'd0) ? emitted_inc : emitted_count;
  assign stop_byte   = (data_byte == 8'd0) ||
                       ((data_byte & POINTER_MASK) == POINTER_MASK);

  always_comb begin
    parse_phase_next     = parse_phase;
    header_count_next    = header_count;
    label_remaining_next = label_remaining;
    emitted_count_next   = emitted_count;
    kind                 = KIND_NONE;
    ch                   = 8'd0;
    status               = 1'b0;
    unique case (parse_phase)
      PH_HEADER: begin
        if (last_byte) begin
          kind   = KIND_FINISH;
          status = 1'b1;
        end else begin
          header_count_next = header_inc;
          if (header_inc >= 4'(HEADER_BYTES)) parse_phase_next = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (emitted_count >= name_limit || stop_byte) begin
          kind             = KIND_FINISH;
          parse_phase_next = PH_DONE;
        end else begin
          if (emitted_count != 8'd0) begin
            ch   = DOT_CHAR;
            kind = KIND_CHAR;
          end
          emitted_count_next = emitted_dot;
          if (emitted_dot >= name_limit) begin
            kind             = KIND_FINISH;
            parse_phase_next = PH_DONE;
          end else begin
            label_remaining_next = data_byte;
            parse_phase_next     = PH_LABEL;
          end
        end
      end
      PH_LABEL: begin
        ch                   = data_byte;
        kind                 = KIND_CHAR;
        emitted_count_next   = emitted_inc;
        label_remaining_next = label_remaining - 8'd1;
        if (emitted_inc >= name_limit) begin
          kind             = KIND_FINISH;
          parse_phase_next = PH_DONE;
        end else if (label_remaining_next == 8'd0) begin
          parse_phase_next = PH_LENGTH;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    // message end also ends a name still in progress
    if (last_byte && (parse_phase == PH_LENGTH || parse_phase == PH_LABEL))
      kind = KIND_FINISH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      name_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_HEADER;
      header_count    <= 4'd0;
      label_remaining <= 8'd0;
      emitted_count   <= 8'd0;
    end else if (accept) begin
      if (last_byte) begin
        parse_phase     <= PH_HEADER;
        header_count    <= 4'd0;
        label_remaining <= 8'd0;
        emitted_count   <= 8'd0;
      end else begin
        parse_phase     <= parse_phase_next;
        header_count    <= header_count_next;
        label_remaining <= label_remaining_next;
        emitted_count   <= emitted_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_kind  <= kind;
      name_char    <= ch;
      name_length  <= emitted_count_next;
      parse_status <= status;
    end
  end

  a_status_finish: assert property (@(posedge clk) disable iff (rst)
    (out_valid && parse_status) |-> (result_kind == KIND_FINISH && name_length == 8'd0))
    else $error("short-message status without finish");

  a_none_no_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_NONE) |-> (name_char == 8'd0))
    else $error("character reported on empty result");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input held off with empty result register");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (parse_phase == PH_HEADER && emitted_count == 8'd0))
    else $error("state not cleared after last byte");

endmodule
